### sv/clock_offset_sliding_median_top_assert.svh
// ----------------------------------------------------------------------------
// clock offset sliding median: assertion macros
// shared assertion forms, sampled on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef CLOCK_OFFSET_SLIDING_MEDIAN_TOP_ASSERT_SVH
`define CLOCK_OFFSET_SLIDING_MEDIAN_TOP_ASSERT_SVH

// same-cycle implication
`define COSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define COSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cosm_pkg.sv
// ----------------------------------------------------------------------------
// cosm_pkg
// shared constants and types of the clock offset sliding median block
// ----------------------------------------------------------------------------
`default_nettype none

package cosm_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;

  // configuration register indexes
  localparam logic [7:0] REG_WINDOW_SIZE     = 8'd0;
  localparam logic [7:0] REG_UPDATE_INTERVAL = 8'd1;

  localparam logic [6:0] WINDOW_SIZE_RESET     = 7'd50;
  localparam logic [7:0] UPDATE_INTERVAL_RESET = 8'd10;

  localparam logic [9:0] NS_PER_US = 10'd1000;
  localparam int         DEV_NS_W  = 42;

  // requests from the top sequencer to the window unit
  typedef struct packed {
    logic push;
    logic start;
  } cosm_ctl_t;

  // status back from the window unit
  typedef struct packed {
    logic done;
  } cosm_sts_t;

endpackage

`default_nettype wire

### sv/cosm_in_if.sv
// ----------------------------------------------------------------------------
// cosm_in_if
// input item channel: offset sample or convert-only request
// ----------------------------------------------------------------------------
`default_nettype none

interface cosm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] device_us;
  logic [62:0] host_ns;

  modport source (output valid, func, device_us, host_ns, input ready);
  modport sink (input valid, func, device_us, host_ns, output ready);
endinterface

`default_nettype wire

### sv/cosm_out_if.sv
// ----------------------------------------------------------------------------
// cosm_out_if
// result item channel: converted time and current offset
// ----------------------------------------------------------------------------
`default_nettype none

interface cosm_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] host_stamp_ns;
  logic signed [63:0] offset_ns;
  logic               median_updated;

  modport source (output valid, host_stamp_ns, offset_ns, median_updated, input ready);
  modport sink (input valid, host_stamp_ns, offset_ns, median_updated, output ready);
endinterface

`default_nettype wire

### sv/cosm_cfg_if.sv
// ----------------------------------------------------------------------------
// cosm_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface cosm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/clock_offset_sliding_median_top.sv
// ----------------------------------------------------------------------------
// clock_offset_sliding_median_top
// device-to-host clock offset estimator with a sliding window median
// ----------------------------------------------------------------------------
// Each sample item (func 0) forms offset = host_ns - device_us * 1000, pushes
// it into a ring of the last window_size offsets and, every update_interval
// samples, replaces the current offset with the window median (even count:
// mean of the two middle values, rounded toward zero). While the current
// offset is zero it follows the latest sample. Every item, convert-only
// (func 1) too, returns one result: device_us * 1000 + current offset,
// wrapping at 64 bits, with the offset and a median flag. One item is taken at
// a time. A sample that recomputes the median ranks each filled window entry
// against every other with the single shared comparator through the one read
// port of the ring memory. A finished result waits in the output register
// while the next item is taken. The ring needs no clearing pass after reset:
// a fill count marks its valid entries. Configuration writes are taken in
// any cycle.
`default_nettype none
`include "clock_offset_sliding_median_top_assert.svh"

module clock_offset_sliding_median_top
  import cosm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cosm_in_if.sink   in_ch,
  cosm_out_if.source out_ch,
  cosm_cfg_if.sink  cfg_ch
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_MED  = 3'd3;
  localparam logic [2:0] S_OFS  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          state_r;

  // configuration registers
  logic [6:0]          ws_r;
  logic [7:0]          ui_r;

  // latched item and working values
  logic                func_r;
  logic [31:0]         dev_us_r;
  logic [62:0]         host_r;
  logic [DEV_NS_W-1:0] dev_ns_r;
  logic [63:0]         offset_r;
  logic [63:0]         cur_r;
  logic [7:0]          ssu_r;
  logic                upd_r;

  // output register
  logic                out_valid_r;
  logic [63:0]         out_stamp_r;
  logic [63:0]         out_off_r;
  logic                out_upd_r;

  cosm_ctl_t           win_ctl;
  cosm_sts_t           win_sts;
  logic [63:0]         win_median;

  logic [63:0]         offset_c;
  logic [7:0]          ssu_nxt;
  logic                trig;
  logic                out_free;

  // config port is always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WINDOW_SIZE_RESET;
      ui_r <= UPDATE_INTERVAL_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WINDOW_SIZE:     ws_r <= cfg_ch.data[6:0];
        REG_UPDATE_INTERVAL: ui_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // offset of the sample and median trigger
  always_comb begin
    offset_c = {1'b0, host_r} - 64'(dev_ns_r);
    ssu_nxt  = ssu_r + 8'd1;
    trig     = (ssu_nxt >= ui_r);
    out_free = !out_valid_r || out_ch.ready;
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign win_ctl.push  = (state_r == S_INS);
  assign win_ctl.start = (state_r == S_INS) && trig;

  cosm_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_size  (ws_r),
    .ctl       (win_ctl),
    .push_data (offset_c),
    .sts       (win_sts),
    .median    (win_median)
  );

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ssu_r   <= '0;
      cur_r   <= '0;
      upd_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r   <= in_ch.func;
            dev_us_r <= in_ch.device_us;
            host_r   <= in_ch.host_ns;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          // 32 x 10 bit product, microseconds to nanoseconds
          dev_ns_r <= DEV_NS_W'(dev_us_r) * DEV_NS_W'(NS_PER_US);
          upd_r    <= 1'b0;
          state_r  <= func_r ? S_OUT : S_INS;
        end
        S_INS: begin
          offset_r <= offset_c;
          if (trig) begin
            ssu_r   <= '0;
            upd_r   <= 1'b1;
            state_r <= S_MED;
          end else begin
            ssu_r   <= ssu_nxt;
            state_r <= S_OFS;
          end
        end
        S_MED: begin
          if (win_sts.done) begin
            cur_r   <= win_median;
            state_r <= S_OFS;
          end
        end
        S_OFS: begin
          // a zero estimate follows the latest sample
          if (cur_r == '0) cur_r <= offset_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register, parts the item side from the result side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_stamp_r <= 64'(dev_ns_r) + cur_r;
      out_off_r   <= cur_r;
      out_upd_r   <= upd_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.host_stamp_ns  = out_stamp_r;
  assign out_ch.offset_ns      = out_off_r;
  assign out_ch.median_updated = out_upd_r;

  // an accepted item blocks the input until its result is queued
  `COSM_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
    "input still ready right after an item was taken")
  // the median engine finishes only while the sequencer waits for it
  `COSM_ASSERT_NOW(a_done_in_med, win_sts.done, state_r == S_MED,
    "median done outside the median wait")
  // convert-only items never start a median
  `COSM_ASSERT_NOW(a_med_only_sample, state_r == S_MED, !func_r && upd_r,
    "median wait for a convert-only item")
  // a result leaving the sequencer lands in the output register
  `COSM_ASSERT_NEXT(a_result_loaded, state_r == S_OUT && out_free, out_ch.valid,
    "result not presented after the sequencer handed it over")

endmodule

`default_nettype wire

### sv/cosm_window.sv
// ----------------------------------------------------------------------------
// cosm_window
// ring of recent offsets and rank-count median engine with one comparator
// ----------------------------------------------------------------------------
`default_nettype none

module cosm_window
  import cosm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [6:0]  win_size,
  input  wire cosm_ctl_t   ctl,
  input  wire logic [63:0] push_data,
  output cosm_sts_t        sts,
  output logic [63:0]      median
);

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_RDV  = 3'd1;
  localparam logic [2:0] R_LDV  = 3'd2;
  localparam logic [2:0] R_CMP  = 3'd3;
  localparam logic [2:0] R_SUM  = 3'd4;
  localparam logic [2:0] R_AVG  = 3'd5;

  function automatic logic [IDX_W-1:0] slot_after(logic [IDX_W-1:0] base,
                                                  logic [FILL_W-1:0] step);
    logic [FILL_W:0] s;
    s = (FILL_W+1)'(base) + {1'b0, step};
    if (s >= (FILL_W+1)'(WINDOW_DEPTH)) s = s - (FILL_W+1)'(WINDOW_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  logic [63:0]       mem [WINDOW_DEPTH];
  logic [63:0]       rdata_r;
  logic [IDX_W-1:0]  rd_addr;

  logic [FILL_W-1:0] fill_r;
  logic [IDX_W-1:0]  oldest_r;

  logic [2:0]        rs_r;
  logic [FILL_W-1:0] i_r, j_r, lt_r, le_r;
  logic              cmp_vld_r;
  logic [63:0]       v_r, a_r, b_r, med_r;
  logic [64:0]       sum_r;
  logic              done_r;

  // window insert
  logic [CMP_W-1:0]  ws_c;
  logic [FILL_W-1:0] ws_eff;
  logic              full;
  logic [IDX_W-1:0]  waddr, oldest1, oldest_nxt;
  logic [FILL_W-1:0] fill1, fill_nxt;
  logic              drop;

  always_comb begin
    ws_c = CMP_W'(win_size);
    if (ws_c == '0) ws_c = CMP_W'(1);
    else if (ws_c > CMP_W'(WINDOW_DEPTH)) ws_c = CMP_W'(WINDOW_DEPTH);
    ws_eff = ws_c[FILL_W-1:0];

    full    = (fill_r == FILL_W'(WINDOW_DEPTH));
    waddr   = full ? oldest_r : slot_after(oldest_r, fill_r);
    fill1   = full ? fill_r : fill_r + 1'b1;
    oldest1 = full ? slot_after(oldest_r, FILL_W'(1)) : oldest_r;
    drop    = (fill1 > ws_eff);
    fill_nxt   = drop ? fill1 - 1'b1 : fill1;
    oldest_nxt = drop ? slot_after(oldest1, FILL_W'(1)) : oldest1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      oldest_r <= '0;
    end else if (ctl.push) begin
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  // ring memory, one write and one registered read port
  always_comb begin
    if (rs_r == R_RDV) rd_addr = slot_after(oldest_r, i_r);
    else rd_addr = slot_after(oldest_r, j_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.push) mem[waddr] <= push_data;
    rdata_r <= mem[rd_addr];
  end

  // rank engine
  logic [FILL_W-1:0] kb, ka, i_nxt;
  logic              issue, w_lt, w_eq;

  always_comb begin
    kb    = fill_r >> 1;
    ka    = kb - 1'b1;
    i_nxt = i_r + 1'b1;
    issue = (j_r < fill_r);
    w_lt  = ($signed(rdata_r) < $signed(v_r));
    w_eq  = (rdata_r == v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r      <= R_IDLE;
      done_r    <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (rs_r)
        R_IDLE: begin
          if (ctl.start) begin
            i_r  <= '0;
            rs_r <= R_RDV;
          end
        end
        R_RDV: begin
          lt_r      <= '0;
          le_r      <= '0;
          j_r       <= '0;
          cmp_vld_r <= 1'b0;
          rs_r      <= R_LDV;
        end
        R_LDV: begin
          v_r  <= rdata_r;
          rs_r <= R_CMP;
        end
        R_CMP: begin
          if (issue) j_r <= j_r + 1'b1;
          cmp_vld_r <= issue;
          if (cmp_vld_r) begin
            lt_r <= lt_r + FILL_W'(w_lt);
            le_r <= le_r + FILL_W'(w_lt | w_eq);
          end
          if (!issue && !cmp_vld_r) begin
            // candidate fully ranked
            if (lt_r <= kb && kb < le_r) b_r <= v_r;
            if (!fill_r[0] && lt_r <= ka && ka < le_r) a_r <= v_r;
            i_r  <= i_nxt;
            rs_r <= (i_nxt == fill_r) ? R_SUM : R_RDV;
          end
        end
        R_SUM: begin
          sum_r <= {a_r[63], a_r} + {b_r[63], b_r};
          rs_r  <= R_AVG;
        end
        R_AVG: begin
          // halve the 65-bit sum, rounding toward zero
          med_r  <= fill_r[0] ? b_r : sum_r[64:1] + 64'(sum_r[64] & sum_r[0]);
          done_r <= 1'b1;
          rs_r   <= R_IDLE;
        end
        default: rs_r <= R_IDLE;
      endcase
    end
  end

  assign sts.done = done_r;
  assign median   = med_r;

endmodule

`default_nettype wire
